FILE: hw/rtl/sdcdc_pkg.sv
// Shared constants for the SD clock divider calculator.
`default_nettype none
package sdcdc_pkg;

	// Operand width of the frequency divider
	localparam int unsigned FREQ_W      = 32;
	// Number of register stages in the restoring divider (one quotient bit each)
	localparam int unsigned DIV_STAGES  = FREQ_W;
	// Stage index of the output register
	localparam int unsigned OUT_STAGE   = DIV_STAGES + 1;

	localparam int unsigned HOST_VER_W  = 8;
	localparam int unsigned FIELD_W     = 16;
	localparam int unsigned SHIFT_W     = 3;

	// Host version at reset, and the first version with a ten-bit divisor
	localparam logic [HOST_VER_W-1:0] HOST_VER_RESET = 8'd2;
	localparam logic [HOST_VER_W-1:0] HOST_VER_WIDE  = 8'd2;

	// Smallest divisor the controller accepts
	localparam logic [FREQ_W-1:0] DIV_MIN = 32'd2;
	// Largest exponent of the power-of-two divisor
	localparam logic [SHIFT_W-1:0] POW2_MAX_SHIFT = 3'd7;

endpackage
`default_nettype wire

FILE: hw/rtl/sd_clock_divider_calc_core.sv
// SD host clock divider calculator: pipelined 32-bit divide plus divisor packing.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) carries one request: base clock in Hz
//   and target card clock in Hz. Master stream (m_tvalid/m_tready/m_tdata) returns
//   the packed 16-bit divider field for the clock control register, one per request,
//   in request order.
//   cfg_we/cfg_wdata write host_version; write it only while no request is in flight.
// Pipeline: a request passes through 33 register stages on its way to m_tvalid:
//   32
//   restoring-divider stages (one quotient bit and one 33-bit compare/subtract
//   each) plus one stage for the exponent, clamp and packing.
// Throughput: one request per cycle while nothing stalls, set by the fully pipelined divider.
// Reset: arst_n clears all stage valid bits and sets host_version to 2.
// Stall: when m_tready is low the result holds on m_tdata. Each stage keeps
//   accepting while a later stage has a bubble, so up to 33 requests can be held
//   before s_tready falls.
`default_nettype none
module sd_clock_divider_calc_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request channel
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // [31:0] base_clock_hz, [63:32] target_hz
	// result channel
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // [15:0] divider_field
	// host_version register
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_wdata
);

	localparam int unsigned W  = sdcdc_pkg::FREQ_W;
	localparam int unsigned NS = sdcdc_pkg::DIV_STAGES;
	localparam int unsigned OS = sdcdc_pkg::OUT_STAGE;

	// host version register
	logic [sdcdc_pkg::HOST_VER_W-1:0] host_version_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_version_q <= sdcdc_pkg::HOST_VER_RESET;
		end else if (cfg_we) begin
			host_version_q <= cfg_wdata;
		end
	end

	// Divider pipeline state: partial remainder, dividend/quotient shift word, divisor
	logic [W-1:0] rem_s [1:NS];
	logic [W-1:0] nq_s  [1:NS];
	logic [W-1:0] den_s [1:NS];
	logic         vld_s [1:OS];
	logic         adv   [1:OS+1];
	logic [sdcdc_pkg::FIELD_W-1:0] field_s33;

	// Per-stage ready: a stage moves when it is empty or the next one moves
	assign adv[OS+1] = m_tready;
	for (genvar k = 1; k <= OS; k++) begin : g_adv
		assign adv[k] = !vld_s[k] || adv[k+1];
	end
	assign s_tready = adv[1];

	// Restoring divider, one quotient bit per stage, MSB first
	for (genvar k = 1; k <= NS; k++) begin : g_div
		logic [W-1:0] rem_in;
		logic [W-1:0] nq_in;
		logic [W-1:0] den_in;
		logic         vld_in;
		logic [W:0]   trial;
		logic [W+1:0] diff;
		logic         ge;

		if (k == 1) begin : g_first
			assign rem_in = '0;
			assign nq_in  = s_tdata[W-1:0];
			assign den_in = s_tdata[2*W-1:W];
			assign vld_in = s_tvalid;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign nq_in  = nq_s[k-1];
			assign den_in = den_s[k-1];
			assign vld_in = vld_s[k-1];
		end

		// shift in next dividend bit and try the subtract
		assign trial = {rem_in, nq_in[W-1]};
		assign diff  = {1'b0, trial} - {2'b00, den_in};
		assign ge    = !diff[W+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k] && vld_in) begin
				rem_s[k] <= ge ? diff[W-1:0] : trial[W-1:0];
				nq_s[k]  <= {nq_in[W-2:0], ge};
				den_s[k] <= den_in;
			end
		end
	end

	// Output stage: exponent of ratio-1, clamp, divisor select and packing
	logic [W-1:0]                      ratio;
	logic [W-1:0]                      ratio_m1;
	logic [sdcdc_pkg::SHIFT_W-1:0]     sh;
	logic [7:0]                        pow2;
	logic [W-1:0]                      div_raw;
	logic [W-1:0]                      div_fix;
	logic                              wide;
	logic [1:0]                        hi_bits;
	logic [sdcdc_pkg::FIELD_W-1:0]     field_d;

	always_comb begin
		ratio    = nq_s[NS];
		ratio_m1 = ratio - W'(1);
		wide     = host_version_q >= sdcdc_pkg::HOST_VER_WIDE;

		// highest set bit index; zero and values of 128 or more count as the top position
		if (ratio_m1 == '0 || ratio_m1[W-1:7] != '0) begin
			sh = sdcdc_pkg::POW2_MAX_SHIFT;
		end else begin
			sh = '0;
			for (int i = 0; i < 7; i++) begin
				if (ratio_m1[i]) begin
					sh = sdcdc_pkg::SHIFT_W'(i);
				end
			end
		end

		pow2    = 8'd1 << sh;
		div_raw = wide ? ratio : {{(W-8){1'b0}}, pow2};
		div_fix = (div_raw <= sdcdc_pkg::DIV_MIN) ? sdcdc_pkg::DIV_MIN : div_raw;
		hi_bits = wide ? div_fix[9:8] : 2'b00;
		field_d = {div_fix[7:0], hi_bits, 6'b000000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[OS] <= 1'b0;
		end else if (adv[OS]) begin
			vld_s[OS] <= vld_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[OS] && vld_s[NS]) begin
			field_s33 <= field_d;
		end
	end

	assign m_tvalid = vld_s[OS];
	assign m_tdata  = field_s33;

endmodule
`default_nettype wire

FILE: hw/rtl/sdcdc_checker.sv
// Port-level checker for the SD clock divider calculator, bound to the top level.
`default_nettype none
module sdcdc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [63:0] s_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic        cfg_we,
	input wire logic [7:0]  cfg_wdata
);

	// shadow of host_version, as seen on the port
	logic [7:0] host_version_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_version_q <= sdcdc_pkg::HOST_VER_RESET;
		end else if (cfg_we) begin
			host_version_q <= cfg_wdata;
		end
	end

	// a stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// with no result pending the pipeline must take a request
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("request refused with empty output");

	// the low six bits of the field are always zero
	a_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[5:0] == 6'd0)
		else $error("reserved field bits set");

	// older hosts get a single power-of-two divisor and no upper bits
	a_narrow_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (host_version_q < sdcdc_pkg::HOST_VER_WIDE)
		|-> $onehot(m_tdata[15:8]) && m_tdata[7:6] == 2'b00)
		else $error("narrow divisor not a power of two");

endmodule

bind sd_clock_divider_calc_core sdcdc_checker u_sdcdc_checker (.*);
`default_nettype wire
